/* src/wcct_pkg.sv */
// weighted color centroid tracker: shared types and constants
// holds the config record, register indexes and reset values; no dependencies
`timescale 1ns / 1ps

package wcct_pkg;

    // config port geometry
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 16;

    // register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_HUE_LIMITS     = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_SAT_LIMITS     = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_VAL_LIMITS     = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_DEFAULT_WEIGHT = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_WEIGHT_FACTOR  = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_WEIGHT_DECAY   = 3'd5;

    // reset values
    localparam logic [15:0] HUE_LIMITS_RST     = 16'hB400;
    localparam logic [15:0] SAT_LIMITS_RST     = 16'hFF00;
    localparam logic [15:0] VAL_LIMITS_RST     = 16'hFF00;
    localparam logic [7:0]  DEFAULT_WEIGHT_RST = 8'd10;
    localparam logic [7:0]  WEIGHT_FACTOR_RST  = 8'd0;
    localparam logic [7:0]  WEIGHT_DECAY_RST   = 8'd0;

    // default weight is given in tenths
    localparam int TENTHS = 10;

    // accumulator widths
    localparam int SUM_XY_BITS = 58;
    localparam int SUM_W_BITS  = 48;

    typedef struct packed {
        logic [15:0] hue_limits;
        logic [15:0] sat_limits;
        logic [15:0] val_limits;
        logic [7:0]  default_weight;
        logic [7:0]  weight_factor;
        logic [7:0]  weight_decay;
    } t_cfg;

endpackage

/* src/wcct_div.sv */
// restoring divider, one quotient bit per cycle
// computes the low QB quotient bits of i_num / i_den; uses no package
`timescale 1ns / 1ps

module wcct_div #(
    parameter int NB = 58,
    parameter int DB = 48,
    parameter int QB = 58
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [NB-1:0] i_num,
    input  logic [DB-1:0] i_den,
    output logic          o_done,
    output logic [QB-1:0] o_quot
);

    localparam int CW = $clog2(QB + 1);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [DB-1:0] r_rem;
    logic [DB-1:0] r_den;
    logic [NB-1:0] r_num;
    logic [QB-1:0] r_q;

    logic [NB-1:0] w_hi;
    logic [DB:0]   w_trial;
    logic [DB:0]   w_diff;
    logic          w_ge;

    // one shift-subtract step
    assign w_hi    = i_num >> QB;
    assign w_trial = {r_rem, r_num[QB-1]};
    assign w_ge    = w_trial >= {1'b0, r_den};
    assign w_diff  = w_trial - {1'b0, r_den};

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(QB);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= w_hi[DB-1:0];
            r_den <= i_den;
            r_num <= i_num;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[DB-1:0] : w_trial[DB-1:0];
            r_num <= {r_num[NB-2:0], 1'b0};
            r_q   <= {r_q[QB-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy) else $error("divider restarted while busy");
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy)) else $error("divider done without work");

endmodule

/* src/wcct_front.sv */
// front end: pixel window test and short queue to the back end
// depends on wcct_pkg for the config record
`timescale 1ns / 1ps

module wcct_front #(
    parameter int X_BITS = 11,
    parameter int Y_BITS = 11
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  wcct_pkg::t_cfg     i_cfg,
    input  logic               i_s_tvalid,
    output logic               o_s_tready,
    input  logic [7:0]         i_hue,
    input  logic [7:0]         i_sat,
    input  logic [7:0]         i_bri,
    input  logic [X_BITS-1:0]  i_x,
    input  logic [Y_BITS-1:0]  i_y,
    input  logic               i_last,
    output logic               o_q_valid,
    input  logic               i_q_ready,
    output logic               o_q_sel,
    output logic               o_q_last,
    output logic [X_BITS-1:0]  o_q_x,
    output logic [Y_BITS-1:0]  o_q_y
);
    import wcct_pkg::*;

    localparam int DEPTH = 4;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [X_BITS-1:0] r_qx   [DEPTH];
    logic [Y_BITS-1:0] r_qy   [DEPTH];
    logic              r_qsel [DEPTH];
    logic              r_qlast[DEPTH];
    logic [PTR_W-1:0]  r_wr;
    logic [PTR_W-1:0]  r_rd;
    logic [CNT_W-1:0]  r_cnt;

    logic w_sel, w_push, w_pop;

    // inclusive hsv window
    assign w_sel = (i_hue >= i_cfg.hue_limits[7:0]) && (i_hue <= i_cfg.hue_limits[15:8])
                && (i_sat >= i_cfg.sat_limits[7:0]) && (i_sat <= i_cfg.sat_limits[15:8])
                && (i_bri >= i_cfg.val_limits[7:0]) && (i_bri <= i_cfg.val_limits[15:8]);

    // beats that neither add weight nor close a frame are dropped here
    assign o_s_tready = (r_cnt != CNT_W'(DEPTH));
    assign w_push     = i_s_tvalid && o_s_tready && (w_sel || i_last);
    assign w_pop      = o_q_valid && i_q_ready;

    // queue storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_qx[r_wr]    <= i_x;
            r_qy[r_wr]    <= i_y;
            r_qsel[r_wr]  <= w_sel;
            r_qlast[r_wr] <= i_last;
        end
    end

    // queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) r_wr <= r_wr + 1'b1;
            if (w_pop)  r_rd <= r_rd + 1'b1;
            if (w_push && !w_pop)      r_cnt <= r_cnt + 1'b1;
            else if (!w_push && w_pop) r_cnt <= r_cnt - 1'b1;
        end
    end

    assign o_q_valid = (r_cnt != '0);
    assign o_q_sel   = r_qsel[r_rd];
    assign o_q_last  = r_qlast[r_rd];
    assign o_q_x     = r_qx[r_rd];
    assign o_q_y     = r_qy[r_rd];

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(DEPTH)) else $error("queue count overflow");

endmodule

/* src/wcct_back.sv */
// back end: pixel weight, accumulation and centroid per frame
// depends on wcct_pkg and wcct_div
`timescale 1ns / 1ps

module wcct_back #(
    parameter int X_BITS    = 11,
    parameter int Y_BITS    = 11,
    parameter int FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  wcct_pkg::t_cfg     i_cfg,
    input  logic               i_q_valid,
    output logic               o_q_ready,
    input  logic               i_q_sel,
    input  logic               i_q_last,
    input  logic [X_BITS-1:0]  i_q_x,
    input  logic [Y_BITS-1:0]  i_q_y,
    output logic               o_m_tvalid,
    input  logic               i_m_tready,
    output logic               o_found,
    output logic [X_BITS-1:0]  o_cx,
    output logic [Y_BITS-1:0]  o_cy
);
    import wcct_pkg::*;

    localparam int DIST_BITS = ((X_BITS > Y_BITS) ? X_BITS : Y_BITS) + 1;
    localparam int DEN_BITS  = DIST_BITS + 8;
    localparam int NUM0_BITS = DEN_BITS + 9;
    localparam int WNB       = NUM0_BITS + FRAC_BITS;
    localparam int WDB       = DEN_BITS + 4;
    localparam int WQB       = 9 + FRAC_BITS;
    localparam int WB        = 8 + FRAC_BITS;

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_DEN  = 9'b000000010,
        S_NUM  = 9'b000000100,
        S_WDIV = 9'b000001000,
        S_PROD = 9'b000010000,
        S_ACC  = 9'b000100000,
        S_FEND = 9'b001000000,
        S_CDIV = 9'b010000000,
        S_OUT  = 9'b100000000
    } t_state;

    t_state                 r_state;
    logic [X_BITS-1:0]      r_x, r_prev_x;
    logic [Y_BITS-1:0]      r_y, r_prev_y;
    logic                   r_last, r_prev_known;
    logic [DIST_BITS-1:0]   r_dist;
    logic [DEN_BITS-1:0]    r_den;
    logic [WB-1:0]          r_w;
    logic [WB+X_BITS-1:0]   r_wx;
    logic [WB+Y_BITS-1:0]   r_wy;
    logic [SUM_XY_BITS-1:0] r_sum_wx, r_sum_wy;
    logic [SUM_W_BITS-1:0]  r_sum_w;
    logic                   r_out_valid, r_found;
    logic [X_BITS-1:0]      r_cx, r_res_x;
    logic [Y_BITS-1:0]      r_cy, r_res_y;

    logic [X_BITS-1:0]      w_ax;
    logic [Y_BITS-1:0]      w_ay;
    logic [NUM0_BITS-1:0]   w_num0;
    logic [WNB-1:0]         w_wnum;
    logic [WDB-1:0]         w_wden;
    logic [WQB-1:0]         w_wq;
    logic [WB-1:0]          w_wsat;
    logic                   w_wdone, w_cdone;
    logic [SUM_XY_BITS-1:0] w_qx, w_qy;
    logic                   w_wstart, w_cstart, w_load;

    // manhattan distance to last position
    assign w_ax = (r_prev_x >= i_q_x) ? r_prev_x - i_q_x : i_q_x - r_prev_x;
    assign w_ay = (r_prev_y >= i_q_y) ? r_prev_y - i_q_y : i_q_y - r_prev_y;

    // weight = (dw*den + 10*wf) / (10*den); with no last position den is one and the wf term is dropped
    assign w_num0 = NUM0_BITS'(i_cfg.default_weight) * NUM0_BITS'(r_den)
                  + (r_prev_known ? NUM0_BITS'(i_cfg.weight_factor) * NUM0_BITS'(TENTHS)
                                  : '0);
    assign w_wnum = {w_num0, {FRAC_BITS{1'b0}}};
    assign w_wden = WDB'(r_den) * WDB'(TENTHS);
    assign w_wsat = w_wq[WQB-1] ? {WB{1'b1}} : w_wq[WB-1:0];

    assign w_wstart = (r_state == S_NUM);
    assign w_cstart = (r_state == S_FEND) && (r_sum_w != '0);
    assign w_load   = (r_state == S_OUT) && (!r_out_valid || i_m_tready);

    wcct_div #(.NB(WNB), .DB(WDB), .QB(WQB)) u_wdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_wstart),
        .i_num   (w_wnum),
        .i_den   (w_wden),
        .o_done  (w_wdone),
        .o_quot  (w_wq)
    );

    wcct_div #(.NB(SUM_XY_BITS), .DB(SUM_W_BITS), .QB(SUM_XY_BITS)) u_xdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_cstart),
        .i_num   (r_sum_wx),
        .i_den   (r_sum_w),
        .o_done  (w_cdone),
        .o_quot  (w_qx)
    );

    wcct_div #(.NB(SUM_XY_BITS), .DB(SUM_W_BITS), .QB(SUM_XY_BITS)) u_ydiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_cstart),
        .i_num   (r_sum_wy),
        .i_den   (r_sum_w),
        .o_done  (),
        .o_quot  (w_qy)
    );

    assign o_q_ready = (r_state == S_IDLE);

    // sequencer and control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_prev_known <= 1'b0;
            r_prev_x     <= '0;
            r_prev_y     <= '0;
            r_sum_wx     <= '0;
            r_sum_wy     <= '0;
            r_sum_w      <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            // result beat held until taken
            if (w_load)                         r_out_valid <= 1'b1;
            else if (r_out_valid && i_m_tready) r_out_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_q_valid) begin
                        if (i_q_sel)       r_state <= S_DEN;
                        else if (i_q_last) r_state <= S_FEND;
                    end
                end
                S_DEN:  r_state <= S_NUM;
                S_NUM:  r_state <= S_WDIV;
                S_WDIV: if (w_wdone) r_state <= S_PROD;
                S_PROD: r_state <= S_ACC;
                S_ACC: begin
                    r_sum_wx <= r_sum_wx + SUM_XY_BITS'(r_wx);
                    r_sum_wy <= r_sum_wy + SUM_XY_BITS'(r_wy);
                    r_sum_w  <= r_sum_w + SUM_W_BITS'(r_w);
                    r_state  <= r_last ? S_FEND : S_IDLE;
                end
                S_FEND: begin
                    if (r_sum_w == '0) begin
                        r_sum_wx <= '0;
                        r_sum_wy <= '0;
                        r_state  <= S_OUT;
                    end else begin
                        r_state <= S_CDIV;
                    end
                end
                S_CDIV: begin
                    if (w_cdone) begin
                        r_prev_x     <= w_qx[X_BITS-1:0];
                        r_prev_y     <= w_qy[Y_BITS-1:0];
                        r_prev_known <= 1'b1;
                        r_sum_wx     <= '0;
                        r_sum_wy     <= '0;
                        r_sum_w      <= '0;
                        r_state      <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (w_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_q_valid) begin
            r_x    <= i_q_x;
            r_y    <= i_q_y;
            r_last <= i_q_last;
            r_dist <= DIST_BITS'(w_ax) + DIST_BITS'(w_ay);
        end
        if (r_state == S_DEN) begin
            r_den <= r_prev_known
                   ? DEN_BITS'(r_dist) * DEN_BITS'(i_cfg.weight_decay) + DEN_BITS'(1)
                   : DEN_BITS'(1);
        end
        if (r_state == S_PROD) begin
            r_w  <= w_wsat;
            r_wx <= (WB + X_BITS)'(w_wsat) * (WB + X_BITS)'(r_x);
            r_wy <= (WB + Y_BITS)'(w_wsat) * (WB + Y_BITS)'(r_y);
        end
        if (r_state == S_FEND) begin
            r_found <= 1'b0;
            r_cx    <= '0;
            r_cy    <= '0;
        end
        if (r_state == S_CDIV && w_cdone) begin
            r_found <= 1'b1;
            r_cx    <= w_qx[X_BITS-1:0];
            r_cy    <= w_qy[Y_BITS-1:0];
        end
        if (w_load) begin
            r_res_x <= r_cx;
            r_res_y <= r_cy;
        end
    end

    // found travels with the result beat
    logic r_res_found;
    always_ff @(posedge i_clk) begin
        if (w_load) r_res_found <= r_found;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_found    = r_res_found;
    assign o_cx       = r_res_x;
    assign o_cy       = r_res_y;

    a_cdiv_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CDIV) |-> (r_sum_w != '0)) else $error("centroid with zero weight");

endmodule

/* src/weighted_color_centroid_tracker.sv */
// weighted color centroid tracker, top level
// per selected pixel the back end steps through distance, denominator, weight divide,
// product and accumulate; at frame end the two centroid dividers (58 bits each) run together
// unselected non-final pixels are dropped by the front end; selected ones are paced by the
// weight divider, one quotient bit per cycle; a 4-deep queue absorbs bursts
// reset: synchronous active low, restores config defaults, clears sums and last position
`timescale 1ns / 1ps

module weighted_color_centroid_tracker #(
    parameter int X_BITS    = 11,
    parameter int Y_BITS    = 11,
    parameter int FRAC_BITS = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [wcct_pkg::CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [wcct_pkg::CFG_DATA_BITS-1:0] i_cfg_data,
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    // hue, saturation, brightness, pix_x, pix_y from bit 0 up, zero padded
    input  logic [((24+X_BITS+Y_BITS+7)/8)*8-1:0] i_s_tdata,
    input  logic                               i_s_tlast,
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    // found, center_x, center_y from bit 0 up, zero padded
    output logic [((1+X_BITS+Y_BITS+7)/8)*8-1:0]  o_m_tdata
);
    import wcct_pkg::*;

    localparam int OUT_W = ((1 + X_BITS + Y_BITS + 7) / 8) * 8;

    t_cfg              r_cfg;
    logic              w_q_valid, w_q_ready, w_q_sel, w_q_last;
    logic [X_BITS-1:0] w_q_x, w_cx;
    logic [Y_BITS-1:0] w_q_y, w_cy;
    logic              w_found;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.hue_limits     <= HUE_LIMITS_RST;
            r_cfg.sat_limits     <= SAT_LIMITS_RST;
            r_cfg.val_limits     <= VAL_LIMITS_RST;
            r_cfg.default_weight <= DEFAULT_WEIGHT_RST;
            r_cfg.weight_factor  <= WEIGHT_FACTOR_RST;
            r_cfg.weight_decay   <= WEIGHT_DECAY_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_HUE_LIMITS:     r_cfg.hue_limits     <= i_cfg_data;
                REG_SAT_LIMITS:     r_cfg.sat_limits     <= i_cfg_data;
                REG_VAL_LIMITS:     r_cfg.val_limits     <= i_cfg_data;
                REG_DEFAULT_WEIGHT: r_cfg.default_weight <= i_cfg_data[7:0];
                REG_WEIGHT_FACTOR:  r_cfg.weight_factor  <= i_cfg_data[7:0];
                REG_WEIGHT_DECAY:   r_cfg.weight_decay   <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    wcct_front #(.X_BITS(X_BITS), .Y_BITS(Y_BITS)) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_hue      (i_s_tdata[7:0]),
        .i_sat      (i_s_tdata[15:8]),
        .i_bri      (i_s_tdata[23:16]),
        .i_x        (i_s_tdata[24 +: X_BITS]),
        .i_y        (i_s_tdata[24 + X_BITS +: Y_BITS]),
        .i_last     (i_s_tlast),
        .o_q_valid  (w_q_valid),
        .i_q_ready  (w_q_ready),
        .o_q_sel    (w_q_sel),
        .o_q_last   (w_q_last),
        .o_q_x      (w_q_x),
        .o_q_y      (w_q_y)
    );

    wcct_back #(.X_BITS(X_BITS), .Y_BITS(Y_BITS), .FRAC_BITS(FRAC_BITS)) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_q_valid  (w_q_valid),
        .o_q_ready  (w_q_ready),
        .i_q_sel    (w_q_sel),
        .i_q_last   (w_q_last),
        .i_q_x      (w_q_x),
        .i_q_y      (w_q_y),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_found    (w_found),
        .o_cx       (w_cx),
        .o_cy       (w_cy)
    );

    // result beat packing
    assign o_m_tdata = OUT_W'({w_cy, w_cx, w_found});

endmodule

/* sim/wcct_checker.sv */
// weighted color centroid tracker: scoreboard that predicts and checks centroid beats
// depends on wcct_pkg for register indexes, reset values and TENTHS
`timescale 1ns / 1ps

module wcct_checker #(
    parameter int X_BITS    = 11,
    parameter int Y_BITS    = 11,
    parameter int FRAC_BITS = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [wcct_pkg::CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [wcct_pkg::CFG_DATA_BITS-1:0] i_cfg_data,
    input  logic                               i_s_tvalid,
    input  logic                               i_s_tready,
    // hue, saturation, brightness, pix_x, pix_y from bit 0 up, zero padded
    input  logic [((24+X_BITS+Y_BITS+7)/8)*8-1:0] i_s_tdata,
    input  logic                               i_s_tlast,
    input  logic                               i_m_tvalid,
    input  logic                               i_m_tready,
    // found, center_x, center_y from bit 0 up, zero padded
    input  logic [((1+X_BITS+Y_BITS+7)/8)*8-1:0]  i_m_tdata,
    output int                                 o_fail_count,
    output int                                 o_pending
);
    import wcct_pkg::*;

    typedef struct packed {
        logic              found;
        logic [X_BITS-1:0] center_x;
        logic [Y_BITS-1:0] center_y;
    } t_centroid;

    localparam logic [63:0] WEIGHT_MAX = (64'd1 << (8 + FRAC_BITS)) - 64'd1;
    localparam logic [63:0] XY_MASK    = (64'd1 << SUM_XY_BITS) - 64'd1;
    localparam logic [63:0] W_MASK     = (64'd1 << SUM_W_BITS) - 64'd1;

    t_cfg        cfg;
    logic [63:0] acc_wx, acc_wy, acc_w;
    logic [63:0] last_x, last_y;
    logic        last_valid;
    t_centroid   centroid_q[$];

    assign o_pending = centroid_q.size();

    function automatic bit in_range(input logic [7:0] v, input logic [15:0] lim);
        return v >= lim[7:0] && v <= lim[15:8];
    endfunction

    // proximity weighted pixel weight, truncated and saturated unsigned Q8.FRAC
    function automatic logic [63:0] pixel_weight(input logic [63:0] x, input logic [63:0] y);
        logic [63:0] manh, den, num, w;
        if (last_valid) begin
            manh = (last_x >= x ? last_x - x : x - last_x)
                 + (last_y >= y ? last_y - y : y - last_y);
            den  = manh * cfg.weight_decay + 64'd1;
            num  = (cfg.default_weight * den + TENTHS * cfg.weight_factor) << FRAC_BITS;
            w    = num / (TENTHS * den);
        end else begin
            w = (64'(cfg.default_weight) << FRAC_BITS) / TENTHS;
        end
        return w > WEIGHT_MAX ? WEIGHT_MAX : w;
    endfunction

    always @(posedge i_clk) begin
        logic [7:0]  h, s, v;
        logic [63:0] x, y, w, cx, cy;
        t_centroid   exp_c, got_c;
        int          bad;
        if (!i_rst_n) begin
            cfg          <= '{HUE_LIMITS_RST, SAT_LIMITS_RST, VAL_LIMITS_RST,
                              DEFAULT_WEIGHT_RST, WEIGHT_FACTOR_RST, WEIGHT_DECAY_RST};
            acc_wx       <= '0;
            acc_wy       <= '0;
            acc_w        <= '0;
            last_x       <= '0;
            last_y       <= '0;
            last_valid   <= 1'b0;
            o_fail_count <= 0;
            centroid_q.delete();
        end else begin
            bad = 0;
            // register writes
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_HUE_LIMITS:     cfg.hue_limits     <= i_cfg_data;
                    REG_SAT_LIMITS:     cfg.sat_limits     <= i_cfg_data;
                    REG_VAL_LIMITS:     cfg.val_limits     <= i_cfg_data;
                    REG_DEFAULT_WEIGHT: cfg.default_weight <= i_cfg_data[7:0];
                    REG_WEIGHT_FACTOR:  cfg.weight_factor  <= i_cfg_data[7:0];
                    REG_WEIGHT_DECAY:   cfg.weight_decay   <= i_cfg_data[7:0];
                    default: ;
                endcase
            end
            // pixel beat: accumulate, and close the frame on tlast
            if (i_s_tvalid && i_s_tready) begin
                h  = i_s_tdata[7:0];
                s  = i_s_tdata[15:8];
                v  = i_s_tdata[23:16];
                x  = 64'(i_s_tdata[24 +: X_BITS]);
                y  = 64'(i_s_tdata[24+X_BITS +: Y_BITS]);
                cx = acc_wx;
                cy = acc_wy;
                w  = acc_w;
                if (in_range(h, cfg.hue_limits) && in_range(s, cfg.sat_limits) &&
                    in_range(v, cfg.val_limits)) begin
                    cx = (acc_wx + pixel_weight(x, y) * x) & XY_MASK;
                    cy = (acc_wy + pixel_weight(x, y) * y) & XY_MASK;
                    w  = (acc_w + pixel_weight(x, y)) & W_MASK;
                end
                if (i_s_tlast) begin
                    if (w != 0) begin
                        exp_c = '{1'b1, X_BITS'(cx / w), Y_BITS'(cy / w)};
                        last_x     <= 64'(exp_c.center_x);
                        last_y     <= 64'(exp_c.center_y);
                        last_valid <= 1'b1;
                    end else begin
                        exp_c = '0;
                    end
                    centroid_q.push_back(exp_c);
                    acc_wx <= '0;
                    acc_wy <= '0;
                    acc_w  <= '0;
                end else begin
                    acc_wx <= cx;
                    acc_wy <= cy;
                    acc_w  <= w;
                end
            end
            // result beat: compare with the oldest expectation
            if (i_m_tvalid && i_m_tready) begin
                got_c = '{i_m_tdata[0], i_m_tdata[1 +: X_BITS], i_m_tdata[1+X_BITS +: Y_BITS]};
                if (centroid_q.size() == 0) begin
                    $display("%0t: unexpected result beat, expected none, got %p", $time, got_c);
                    bad++;
                end else begin
                    exp_c = centroid_q.pop_front();
                    if (got_c.found !== exp_c.found) begin
                        $display("%0t: found expected %0d got %0d", $time, exp_c.found,
                                 got_c.found);
                        bad++;
                    end
                    if (got_c.center_x !== exp_c.center_x) begin
                        $display("%0t: center_x expected %0d got %0d", $time,
                                 exp_c.center_x, got_c.center_x);
                        bad++;
                    end
                    if (got_c.center_y !== exp_c.center_y) begin
                        $display("%0t: center_y expected %0d got %0d", $time,
                                 exp_c.center_y, got_c.center_y);
                        bad++;
                    end
                end
            end
            o_fail_count <= o_fail_count + bad;
        end
    end

endmodule

/* sim/weighted_color_centroid_tracker_test.sv */
// weighted color centroid tracker testbench top: clock, reset, pixel and config stimulus
// depends on wcct_pkg, the tracker RTL and wcct_checker
`timescale 1ns / 1ps

module weighted_color_centroid_tracker_test;
    import wcct_pkg::*;

    localparam int XB = 11;
    localparam int YB = 11;
    localparam int FB = 16;
    localparam int CYCLE_LIMIT = 1000000;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_cfg_we = 1'b0;
    logic [CFG_IDX_BITS-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_BITS-1:0] i_cfg_data = '0;
    logic                     i_s_tvalid = 1'b0;
    logic                     o_s_tready;
    // hue, saturation, brightness, pix_x, pix_y from bit 0 up, zero padded
    logic [47:0]              i_s_tdata = '0;
    logic                     i_s_tlast = 1'b0;
    logic                     o_m_tvalid;
    logic                     i_m_tready = 1'b0;
    // found, center_x, center_y from bit 0 up, zero padded
    logic [23:0]              o_m_tdata;

    int fail_count, pending, cycles, stall_left;
    bit calm = 1'b0;
    logic [15:0] hue_lim, sat_lim, val_lim;
    logic [10:0] aim_x, aim_y;

    weighted_color_centroid_tracker #(.X_BITS(XB), .Y_BITS(YB), .FRAC_BITS(FB)) DUT (.*);

    wcct_checker #(.X_BITS(XB), .Y_BITS(YB), .FRAC_BITS(FB)) scoreboard (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .i_s_tvalid, .i_s_tready(o_s_tready), .i_s_tdata, .i_s_tlast,
        .i_m_tvalid(o_m_tvalid), .i_m_tready, .i_m_tdata(o_m_tdata),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("** weighted_color_centroid_tracker: FAILED **");
            $finish;
        end
    end

    // result side backpressure in bursts
    always @(posedge i_clk) begin
        if (!i_rst_n || calm) begin
            i_m_tready <= i_rst_n;
            stall_left <= 0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_m_tready <= 1'b0;
        end else if ($urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(0, 7);
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    // all tasks start and end just after a rising edge
    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [15:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        if (idx == REG_HUE_LIMITS) hue_lim = val;
        if (idx == REG_SAT_LIMITS) sat_lim = val;
        if (idx == REG_VAL_LIMITS) val_lim = val;
    endtask

    // hold off the pixel stream until every centroid is out and the pipe is empty
    task automatic drain();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        wait (pending == 0);
        @(posedge i_clk);
        repeat (300) @(posedge i_clk);
    endtask

    task automatic send_pixel(input logic [7:0] h, s, v, input logic [10:0] x, y,
                              input bit last);
        bit ok;
        if (!calm && $urandom_range(0, 3) == 0) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {2'b00, y, x, v, s, h};
        i_s_tlast  <= last;
        do begin
            @(negedge i_clk);
            ok = o_s_tready;
            @(posedge i_clk);
        end while (!ok);
    endtask

    // channel value, mostly inside the current window
    function automatic logic [7:0] pick(input logic [15:0] lim, input int top);
        int lo, hi;
        lo = lim[7:0];
        hi = lim[15:8] > top ? top : lim[15:8];
        if (lo <= hi && $urandom_range(0, 9) < 8) return 8'($urandom_range(lo, hi));
        return 8'($urandom_range(0, top));
    endfunction

    // one frame of n pixels, mostly clustered around an aim point
    task automatic run_frame(input int n);
        logic [10:0] x, y;
        if ($urandom_range(0, 3) == 0) begin
            aim_x = 11'($urandom);
            aim_y = 11'($urandom);
        end
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 4) == 0) begin
                x = 11'($urandom);
                y = 11'($urandom);
            end else begin
                x = 11'(aim_x + $urandom_range(0, 40) - 20);
                y = 11'(aim_y + $urandom_range(0, 40) - 20);
            end
            send_pixel(pick(hue_lim, 180), pick(sat_lim, 255), pick(val_lim, 255),
                       x, y, i == n - 1);
        end
    endtask

    function automatic logic [15:0] rand_window();
        logic [7:0] a, b;
        a = 8'($urandom);
        b = 8'($urandom);
        if ($urandom_range(0, 7) == 0) return {a, b};
        return a < b ? {b, a} : {a, b};
    endfunction

    initial begin
        hue_lim = HUE_LIMITS_RST;
        sat_lim = SAT_LIMITS_RST;
        val_lim = VAL_LIMITS_RST;
        aim_x   = 11'd300;
        aim_y   = 11'd200;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // extremes under reset settings, a lone last pixel, then an empty frame
        send_pixel(8'd0, 8'd0, 8'd0, 11'd0, 11'd0, 1'b0);
        send_pixel(8'd180, 8'd255, 8'd255, 11'd2047, 11'd2047, 1'b1);
        send_pixel(8'd90, 8'd128, 8'd127, 11'd1024, 11'd1023, 1'b1);
        send_pixel(8'd181, 8'd10, 8'd10, 11'd5, 11'd5, 1'b1);
        drain();
        // proximity bonus at its largest, with and without distance decay
        write_reg(REG_DEFAULT_WEIGHT, 16'd200);
        write_reg(REG_WEIGHT_FACTOR, 16'd200);
        write_reg(REG_WEIGHT_DECAY, 16'd0);
        send_pixel(8'd10, 8'd10, 8'd10, 11'd1023, 11'd1024, 1'b0);
        send_pixel(8'd10, 8'd10, 8'd10, 11'd1024, 11'd1023, 1'b1);
        send_pixel(8'd10, 8'd10, 8'd10, 11'd0, 11'd2047, 1'b0);
        send_pixel(8'd10, 8'd10, 8'd10, 11'd1023, 11'd1023, 1'b1);
        drain();
        write_reg(REG_WEIGHT_DECAY, 16'd200);
        write_reg(REG_DEFAULT_WEIGHT, 16'd0);
        send_pixel(8'd10, 8'd10, 8'd10, 11'd2047, 11'd0, 1'b0);
        send_pixel(8'd10, 8'd10, 8'd10, 11'd1023, 11'd1023, 1'b1);
        drain();
        // empty hue window: nothing is selected
        write_reg(REG_HUE_LIMITS, 16'h1050);
        write_reg(REG_SAT_LIMITS, 16'hFF00);
        write_reg(REG_VAL_LIMITS, 16'hFF00);
        send_pixel(8'd20, 8'd20, 8'd20, 11'd1, 11'd1, 1'b0);
        send_pixel(8'd80, 8'd20, 8'd20, 11'd2, 11'd2, 1'b1);
        drain();

        // random phases of settings and frames
        for (int p = 0; p < 9; p++) begin
            case (p)
                0: begin
                    write_reg(REG_HUE_LIMITS, 16'hFF00);
                    write_reg(REG_SAT_LIMITS, 16'hFF00);
                    write_reg(REG_VAL_LIMITS, 16'hFF00);
                    write_reg(REG_DEFAULT_WEIGHT, 16'd200);
                    write_reg(REG_WEIGHT_FACTOR, 16'd200);
                    write_reg(REG_WEIGHT_DECAY, 16'd200);
                end
                1: begin
                    write_reg(REG_DEFAULT_WEIGHT, 16'd0);
                    write_reg(REG_WEIGHT_FACTOR, 16'd0);
                    write_reg(REG_WEIGHT_DECAY, 16'd0);
                end
                default: begin
                    write_reg(REG_HUE_LIMITS, rand_window());
                    write_reg(REG_SAT_LIMITS, rand_window());
                    write_reg(REG_VAL_LIMITS, rand_window());
                    write_reg(REG_DEFAULT_WEIGHT, 16'($urandom_range(0, 200)));
                    write_reg(REG_WEIGHT_FACTOR, 16'($urandom_range(0, 200)));
                    write_reg(REG_WEIGHT_DECAY, 16'($urandom_range(0, 200)));
                end
            endcase
            if (p == 8) calm = 1'b1;
            for (int n = 0; n < 210; ) begin
                int len;
                len = $urandom_range(0, 7) == 0 ? $urandom_range(20, 40) : $urandom_range(1, 12);
                run_frame(len);
                n += len;
            end
            drain();
        end

        if (fail_count == 0) begin
            $display("** weighted_color_centroid_tracker: PASSED **");
        end else begin
            $display("** weighted_color_centroid_tracker: FAILED **");
        end
        $finish;
    end

endmodule
